[rtl/core/quoted_word_splitter_unit_assert.svh]
// Assertion macros for the quoted word splitter
`ifndef QUOTED_WORD_SPLITTER_UNIT_ASSERT_SVH
`define QUOTED_WORD_SPLITTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define QWS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("quoted word splitter: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset
`define QWS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("quoted word splitter: next-cycle check failed");

`endif

[rtl/core/qws_pkg.sv]
// Types, codes and helpers used by the quoted word splitter unit
package qws_pkg;

	localparam logic [1:0] KIND_CHAR     = 2'd0;
	localparam logic [1:0] KIND_WORD_END = 2'd1;
	localparam logic [1:0] KIND_STR_END  = 2'd2;

	localparam logic [7:0] QUOTE_CHAR = 8'h22;
	localparam logic [7:0] NUL_CHAR   = 8'h00;
	localparam logic [7:0] MAX_WORDS_RESET = 8'd16;

	localparam int unsigned MAX_RESULTS = 3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic [7:0] word_index;
	} res_t;

	typedef logic [$clog2(MAX_RESULTS+1)-1:0] res_cnt_t;

	function automatic logic is_blank(input logic [7:0] b);
		return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
	endfunction

	function automatic res_t make_res(input logic [1:0] kind, input logic [7:0] b,
		input logic [7:0] idx);
		res_t r;
		r.kind       = kind;
		r.out_byte   = b;
		r.word_index = idx;
		return r;
	endfunction

endpackage

[rtl/core/qws_char_if.sv]
// Character channel: one input byte item with its flags
interface qws_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       byte_valid;
	logic       is_last;

	modport source (output valid, output in_byte, output byte_valid, output is_last,
		input ready);
	modport sink (input valid, input in_byte, input byte_valid, input is_last,
		output ready);
endinterface

[rtl/core/qws_tok_if.sv]
// Token channel: one result item of the splitter
interface qws_tok_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic [7:0] word_index;
	logic       run_last;

	modport source (output valid, output kind, output out_byte, output word_index,
		output run_last, input ready);
	modport sink (input valid, input kind, input out_byte, input word_index,
		input run_last, output ready);
endinterface

[rtl/core/quoted_word_splitter_unit.sv]
// Quoted word splitter: top level with input register, token logic and result buffer
//
//  channel   dir  payload                                   accepted when
//  chars     in   in_byte[8], byte_valid, is_last          valid & ready
//  tokens    out  kind[2], out_byte[8], word_index[8], run_last  valid & ready
//  cfg       in   cfg_wdata[8] -> max_words                cfg_we
//
// One item per cycle when it gives at most one token and tokens are taken; an item
// giving more than one token holds the input side until its last token is taken.
// An item goes through the input register and then the result buffer.
// Reset clears all string state and sets max_words to 16.
// A stalled token buffer stops the input register, which stops chars.ready.
`include "quoted_word_splitter_unit_assert.svh"

module quoted_word_splitter_unit (
	input  logic        clk,
	input  logic        arst_n,
	qws_char_if.sink    chars,
	qws_tok_if.source   tokens,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	logic [7:0] max_words_q;

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       bvalid_s1;
	logic       last_s1;

	logic       in_word_q;
	logic       quoting_q;
	logic       quote_pending_q;
	logic [7:0] word_count_q;
	logic       stopped_q;

	qws_pkg::res_t     res_q [qws_pkg::MAX_RESULTS];
	qws_pkg::res_cnt_t cnt_q;

	qws_pkg::res_t     res_new [qws_pkg::MAX_RESULTS];
	qws_pkg::res_cnt_t n_new;
	logic       iw_d, qt_d, qp_d, st_d;
	logic [7:0] wc_d;

	logic pop, load, adv_s1;

	assign pop    = tokens.valid && tokens.ready;
	assign load   = (cnt_q == '0) || ((cnt_q == qws_pkg::res_cnt_t'(1)) && pop);
	assign adv_s1 = v_s1 && load;
	assign chars.ready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_words_q <= qws_pkg::MAX_WORDS_RESET;
		end else if (cfg_we) begin
			max_words_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (chars.ready) begin
			v_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			byte_s1   <= chars.in_byte;
			bvalid_s1 <= chars.byte_valid;
			last_s1   <= chars.is_last;
		end
	end

	// token logic for the item in the input register
	always_comb begin
		logic pair;
		iw_d = in_word_q;
		qt_d = quoting_q;
		qp_d = quote_pending_q;
		wc_d = word_count_q;
		st_d = stopped_q;
		n_new = '0;
		pair = 1'b0;
		for (int i = 0; i < qws_pkg::MAX_RESULTS; i++) begin
			res_new[i] = qws_pkg::make_res(qws_pkg::KIND_CHAR, 8'd0, 8'd0);
		end

		if (bvalid_s1 && !st_d) begin
			if (byte_s1 == qws_pkg::NUL_CHAR) begin
				if (qp_d) begin
					qt_d = !qt_d;
					qp_d = 1'b0;
				end
				if (iw_d) begin
					res_new[n_new] = qws_pkg::make_res(qws_pkg::KIND_WORD_END, 8'd0,
						wc_d - 8'd1);
					n_new = n_new + qws_pkg::res_cnt_t'(1);
					iw_d = 1'b0;
				end
				st_d = 1'b1;
			end else if (iw_d || !qws_pkg::is_blank(byte_s1)) begin
				if (!iw_d) begin
					// start a new word unless the limit is reached
					if (wc_d >= max_words_q) begin
						st_d = 1'b1;
						pair = 1'b1;
					end else begin
						wc_d = wc_d + 8'd1;
						iw_d = 1'b1;
						qt_d = 1'b0;
						qp_d = 1'b0;
					end
				end else if (qp_d) begin
					qp_d = 1'b0;
					if (byte_s1 == qws_pkg::QUOTE_CHAR) begin
						res_new[n_new] = qws_pkg::make_res(qws_pkg::KIND_CHAR,
							qws_pkg::QUOTE_CHAR, wc_d - 8'd1);
						n_new = n_new + qws_pkg::res_cnt_t'(1);
						pair = 1'b1;
					end else begin
						qt_d = !qt_d;
					end
				end
				if (!pair) begin
					if (byte_s1 == qws_pkg::QUOTE_CHAR) begin
						qp_d = 1'b1;
					end else if (qt_d || !qws_pkg::is_blank(byte_s1)) begin
						res_new[n_new] = qws_pkg::make_res(qws_pkg::KIND_CHAR, byte_s1,
							wc_d - 8'd1);
						n_new = n_new + qws_pkg::res_cnt_t'(1);
					end else begin
						res_new[n_new] = qws_pkg::make_res(qws_pkg::KIND_WORD_END, 8'd0,
							wc_d - 8'd1);
						n_new = n_new + qws_pkg::res_cnt_t'(1);
						iw_d = 1'b0;
					end
				end
			end
		end

		if (last_s1) begin
			if (!st_d) begin
				if (qp_d) begin
					qt_d = !qt_d;
					qp_d = 1'b0;
				end
				if (iw_d) begin
					res_new[n_new] = qws_pkg::make_res(qws_pkg::KIND_WORD_END, 8'd0,
						wc_d - 8'd1);
					n_new = n_new + qws_pkg::res_cnt_t'(1);
				end
			end
			res_new[n_new] = qws_pkg::make_res(qws_pkg::KIND_STR_END, 8'd0, wc_d);
			n_new = n_new + qws_pkg::res_cnt_t'(1);
			iw_d = 1'b0;
			qt_d = 1'b0;
			qp_d = 1'b0;
			wc_d = 8'd0;
			st_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q       <= 1'b0;
			quoting_q       <= 1'b0;
			quote_pending_q <= 1'b0;
			word_count_q    <= 8'd0;
			stopped_q       <= 1'b0;
		end else if (adv_s1) begin
			in_word_q       <= iw_d;
			quoting_q       <= qt_d;
			quote_pending_q <= qp_d;
			word_count_q    <= wc_d;
			stopped_q       <= st_d;
		end
	end

	// result buffer: load a whole item's tokens, shift one out per handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= v_s1 ? n_new : '0;
		end else if (pop) begin
			cnt_q <= cnt_q - qws_pkg::res_cnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res_new;
		end else if (pop) begin
			for (int i = 0; i < qws_pkg::MAX_RESULTS - 1; i++) begin
				res_q[i] <= res_q[i+1];
			end
		end
	end

	assign tokens.valid      = (cnt_q != '0);
	assign tokens.kind       = res_q[0].kind;
	assign tokens.out_byte   = res_q[0].out_byte;
	assign tokens.word_index = res_q[0].word_index;
	assign tokens.run_last   = (cnt_q == qws_pkg::res_cnt_t'(1));

	`QWS_ASSERT_NOW(a_word_counted, in_word_q, word_count_q != 8'd0)
	`QWS_ASSERT_NOW(a_quote_in_word, quote_pending_q, in_word_q)
	`QWS_ASSERT_NOW(a_str_end_last, tokens.valid && (tokens.kind == qws_pkg::KIND_STR_END),
		tokens.run_last)
	`QWS_ASSERT_NEXT(a_load_shows, adv_s1 && (n_new != '0), tokens.valid)
	`QWS_ASSERT_NEXT(a_pop_drains, pop && !load, cnt_q == $past(cnt_q) - qws_pkg::res_cnt_t'(1))

endmodule
